### design/pspi_pkg.sv
// pspi_pkg: shared sizes, beat types, opcodes and memory request structs
// for the per-symbol position index; no dependencies
`timescale 1ns / 1ps

package pspi_pkg;

  localparam int NUM_SYMBOLS = 256;
  localparam int LIST_DEPTH  = 16;
  localparam int POS_WIDTH   = 16;

  localparam int SYM_W       = $clog2(NUM_SYMBOLS);
  localparam int IDX_W       = $clog2(LIST_DEPTH);
  localparam int LEN_W       = $clog2(LIST_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_SYMBOLS * (1 << IDX_W);
  localparam int STORE_AW    = SYM_W + IDX_W;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [SYM_W-1:0]     sym_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  symbol;
    logic [15:0] position;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] next_position;
    logic        status;
  } out_beat_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    pos_t                wdata;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic we;
    sym_t waddr;
    len_t wdata;
    sym_t raddr;
  } len_req_t;

  function automatic pos_t to_pos(input logic [15:0] p);
    logic [POS_WIDTH+15:0] ext;
    ext = {{POS_WIDTH{1'b0}}, p};
    return ext[POS_WIDTH-1:0];
  endfunction

  function automatic logic [15:0] to_field(input pos_t v);
    logic [POS_WIDTH+15:0] ext;
    ext = {16'h0000, v};
    return ext[15:0];
  endfunction

endpackage

### design/per_symbol_position_index.sv
// per_symbol_position_index: top level with the two memories, the sequencer
// and the result register; uses pspi_pkg, pspi_ram and pspi_seq
// steps: accept a beat in ST_IDLE; in ST_LEN take the list length and do append
// or clear; for query/delete on a non-empty list read up to LIST_DEPTH entries in
// ST_SCAN; ST_DONE waits out output stalls, and only then is a new beat taken
// reset clears all list lengths at once by per-symbol valid flags; no clearing pass
`timescale 1ns / 1ps

module per_symbol_position_index import pspi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  store_req_t st_req;
  pos_t       st_rdata;
  len_req_t   ln_req;
  len_t       ln_rdata;
  logic       res_valid;
  out_beat_t  res_data;
  logic       res_ready;

  logic       out_valid_r, out_valid_nxt;
  out_beat_t  out_data_r, out_data_nxt;

  pspi_ram #(
    .WIDTH (POS_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_req.we),
    .waddr (st_req.waddr),
    .wdata (st_req.wdata),
    .raddr (st_req.raddr),
    .rdata (st_rdata)
  );

  pspi_ram #(
    .WIDTH (LEN_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_len (
    .clk   (clk),
    .we    (ln_req.we),
    .waddr (ln_req.waddr),
    .wdata (ln_req.wdata),
    .raddr (ln_req.raddr),
    .rdata (ln_rdata)
  );

  pspi_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .st_req    (st_req),
    .st_rdata  (st_rdata),
    .ln_req    (ln_req),
    .ln_rdata  (ln_rdata),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  // output register frees when empty or draining
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/pspi_ram.sv
// pspi_ram: generic single-write, single-read memory with registered read
// no dependencies
`timescale 1ns / 1ps

module pspi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/pspi_seq.sv
// pspi_seq: sequencer that reads, modifies and writes back the list lengths
// and the position store; uses pspi_pkg
`timescale 1ns / 1ps

module pspi_seq import pspi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_data,
  output store_req_t st_req,
  input  pos_t       st_rdata,
  output len_req_t   ln_req,
  input  len_t       ln_rdata,
  output logic       res_valid,
  output out_beat_t  res_data,
  input  logic       res_ready
);

  typedef enum logic [1:0] {ST_IDLE, ST_LEN, ST_SCAN, ST_DONE} state_t;

  state_t           state_r, state_nxt;
  opcode_t          op_r, op_nxt;
  sym_t             sym_r, sym_nxt;
  logic             symok_r, symok_nxt;
  pos_t             pos_r, pos_nxt;
  len_t             len_r, len_nxt;
  len_t             di_r, di_nxt;
  len_t             wr_r, wr_nxt;
  out_beat_t        res_r, res_nxt;
  logic [NUM_SYMBOLS-1:0] vld_r, vld_nxt;

  len_t len_cur;
  len_t di_inc;
  len_t wr_inc;
  logic keep;
  logic last;

  assign len_cur = vld_r[sym_r] ? ln_rdata : '0;
  assign di_inc  = di_r + LEN_W'(1);
  assign last    = (di_inc == len_r);
  assign keep    = (st_rdata != pos_r);
  assign wr_inc  = wr_r + LEN_W'(keep);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    sym_nxt   = sym_r;
    symok_nxt = symok_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    di_nxt    = di_r;
    wr_nxt    = wr_r;
    res_nxt   = res_r;
    vld_nxt   = vld_r;
    in_stall  = 1'b1;
    res_valid = 1'b0;

    st_req.we    = 1'b0;
    st_req.waddr = {sym_r, wr_r[IDX_W-1:0]};
    st_req.wdata = st_rdata;
    st_req.raddr = {sym_r, di_inc[IDX_W-1:0]};

    ln_req.we    = 1'b0;
    ln_req.waddr = sym_r;
    ln_req.wdata = wr_inc;
    ln_req.raddr = sym_r;

    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        ln_req.raddr = in_data.symbol[SYM_W-1:0];
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          sym_nxt   = in_data.symbol[SYM_W-1:0];
          symok_nxt = ({1'b0, in_data.symbol} < 9'(NUM_SYMBOLS));
          pos_nxt   = to_pos(in_data.position);
          res_nxt   = '0;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        len_nxt   = len_cur;
        di_nxt    = '0;
        wr_nxt    = '0;
        state_nxt = ST_DONE;
        if (op_r == OP_CLEAR) begin
          vld_nxt = '0;
        end else if (symok_r) begin
          unique case (op_r)
            OP_APPEND: begin
              if (len_cur >= LEN_W'(LIST_DEPTH)) begin
                res_nxt.status = STATUS_FULL;
              end else begin
                st_req.we     = 1'b1;
                st_req.waddr  = {sym_r, len_cur[IDX_W-1:0]};
                st_req.wdata  = pos_r;
                ln_req.we     = 1'b1;
                ln_req.wdata  = len_cur + LEN_W'(1);
                vld_nxt[sym_r] = 1'b1;
              end
            end
            OP_DELETE, OP_QUERY: begin
              st_req.raddr = {sym_r, {IDX_W{1'b0}}};
              if (len_cur != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        di_nxt = di_inc;
        if (op_r == OP_QUERY) begin
          if (st_rdata > pos_r) begin
            res_nxt.next_position = to_field(st_rdata);
            state_nxt = ST_DONE;
          end else if (last) begin
            state_nxt = ST_DONE;
          end
        end else begin
          st_req.we = keep;
          wr_nxt    = wr_inc;
          if (last) begin
            ln_req.we = 1'b1;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    op_r    <= op_nxt;
    sym_r   <= sym_nxt;
    symok_r <= symok_nxt;
    pos_r   <= pos_nxt;
    len_r   <= len_nxt;
    di_r    <= di_nxt;
    wr_r    <= wr_nxt;
    res_r   <= res_nxt;
  end

  assign res_data = res_r;

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (di_r < len_r))
    else $error("scan index past list length");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (wr_r <= di_r))
    else $error("compaction write ahead of read");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ln_req.we |-> (ln_req.wdata <= LEN_W'(LIST_DEPTH)))
    else $error("list length written beyond depth");

  a_store_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.we |-> (state_r == ST_LEN || state_r == ST_SCAN))
    else $error("position store written outside an operation");
`endif

endmodule

### dv/position_index_checker.sv
// position_index_checker: watches both channels of the per-symbol position index,
// keeps its own copy of the per-symbol lists and compares every result beat
// depends on pspi_pkg
`timescale 1ns / 1ps

module position_index_checker import pspi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_data,
  output int        errors,
  output int        pending
);

  pos_t        pos_mem [NUM_SYMBOLS][LIST_DEPTH];
  int unsigned list_len [NUM_SYMBOLS];
  out_beat_t   awaited_beats [$];
  int          fail_cnt;

  initial begin
    errors   = 0;
    pending  = 0;
    fail_cnt = 0;
  end

  // applies one operation to the mirrored lists and returns the result beat
  function automatic out_beat_t apply_index_op(in_beat_t b);
    logic [31:0] wide;
    pos_t        p;
    int unsigned s;
    int unsigned n;
    int unsigned keep;
    int unsigned i;
    logic        hit;
    out_beat_t   r;
    wide = 32'(b.position);
    p    = wide[POS_WIDTH-1:0];
    s    = b.symbol;
    r    = '0;
    r.status = STATUS_OK;
    hit  = 1'b0;
    if (b.opcode == OP_CLEAR) begin
      foreach (list_len[k]) list_len[k] = 0;
    end else if (s < NUM_SYMBOLS) begin
      n = list_len[s];
      case (b.opcode)
        OP_APPEND: begin
          if (n >= LIST_DEPTH) begin
            r.status = STATUS_FULL;
          end else begin
            pos_mem[s][n] = p;
            list_len[s]   = n + 1;
          end
        end
        OP_DELETE: begin
          keep = 0;
          for (i = 0; i < n; i++) begin
            if (pos_mem[s][i] != p) begin
              pos_mem[s][keep] = pos_mem[s][i];
              keep++;
            end
          end
          list_len[s] = keep;
        end
        default: begin
          for (i = 0; i < n; i++) begin
            if (!hit && pos_mem[s][i] > p) begin
              hit = 1'b1;
              r.next_position = 16'(pos_mem[s][i]);
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      foreach (list_len[k]) list_len[k] = 0;
      awaited_beats.delete();
    end else begin
      if (in_valid && !in_stall) awaited_beats.push_back(apply_index_op(in_data));
      if (out_valid && !out_stall) begin
        if (awaited_beats.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result beat, expected none, got next_position %h status %b",
                   $time, out_data.next_position, out_data.status);
        end else begin
          want = awaited_beats.pop_front();
          if (out_data.next_position !== want.next_position) begin
            fail_cnt++;
            $display("%0t: next_position mismatch, expected %h, got %h",
                     $time, want.next_position, out_data.next_position);
          end
          if (out_data.status !== want.status) begin
            fail_cnt++;
            $display("%0t: status mismatch, expected %b, got %b",
                     $time, want.status, out_data.status);
          end
        end
      end
    end
    errors  <= fail_cnt;
    pending <= awaited_beats.size();
  end

endmodule

### dv/tb.sv
// tb: drives random and directed beats into per_symbol_position_index with idle gaps
// and output stalls, and gives the verdict; depends on pspi_pkg and position_index_checker
`timescale 1ns / 1ps

module tb import pspi_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 6;
  localparam int PHASE_BEATS    = 275;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  int        errors;
  int        pending;
  int        idle_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  per_symbol_position_index i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  position_index_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic issue(input opcode_t opc, input logic [7:0] sym, input logic [15:0] pos,
                       input int unsigned gap);
    in_beat_t b;
    b.opcode   = opc;
    b.symbol   = sym;
    b.position = pos;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: free runs, sometimes long ones, broken by stalls
  initial begin : receiver
    int unsigned free_run;
    int unsigned hold;
    forever begin
      out_stall <= 1'b0;
      free_run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
      repeat (free_run) @(posedge clk);
      hold = pick_gap();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0]  hot [3];
    logic [15:0] pool [8];
    in_beat_t    b;
    int unsigned app_pct;
    int unsigned del_pct;
    int unsigned r;
    logic        burst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stored zero, extremes, duplicates, absent delete, empty list
    issue(OP_APPEND, 8'hFF, 16'h0000, pick_gap());
    issue(OP_APPEND, 8'hFF, 16'hFFFF, pick_gap());
    issue(OP_APPEND, 8'hFF, 16'h8000, pick_gap());
    issue(OP_APPEND, 8'hFF, 16'h8000, pick_gap());
    issue(OP_QUERY,  8'hFF, 16'h0000, pick_gap());
    issue(OP_QUERY,  8'hFF, 16'hFFFF, pick_gap());
    issue(OP_DELETE, 8'hFF, 16'h8000, pick_gap());
    issue(OP_DELETE, 8'hFF, 16'h1234, pick_gap());
    issue(OP_QUERY,  8'hFF, 16'h7FFF, pick_gap());
    issue(OP_QUERY,  8'h00, 16'h0000, pick_gap());
    // fill the list and overflow it
    repeat (LIST_DEPTH - 1) issue(OP_APPEND, 8'hFF, 16'($urandom), pick_gap());
    issue(OP_CLEAR, 8'h5A, 16'hA5A5, pick_gap());
    issue(OP_QUERY, 8'hFF, 16'h0000, 0);
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      foreach (hot[k]) hot[k] = 8'($urandom);
      foreach (pool[k]) pool[k] = 16'($urandom);
      pool[0] = 16'h0000;
      pool[7] = 16'hFFFF;
      app_pct = $urandom_range(35, 60);
      del_pct = app_pct + $urandom_range(10, 25);
      burst   = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        r = $urandom_range(0, 199);
        if (r == 0) b.opcode = OP_CLEAR;
        else if (r < 2 * app_pct) b.opcode = OP_APPEND;
        else if (r < 2 * del_pct) b.opcode = OP_DELETE;
        else b.opcode = OP_QUERY;
        b.symbol   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : hot[$urandom_range(0, 2)];
        b.position = ($urandom_range(0, 2) == 0) ? 16'($urandom) : pool[$urandom_range(0, 7)];
        issue(b.opcode, b.symbol, b.position, burst ? 0 : pick_gap());
      end
      drain_results();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
design/pspi_pkg.sv
design/pspi_ram.sv
design/pspi_seq.sv
design/per_symbol_position_index.sv
dv/position_index_checker.sv
dv/tb.sv
